@@ hdl/gtb_pkg.sv @@
`timescale 1ns / 1ps

package gtb_pkg;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [2:0] REG_WAVE_TYPE       = 3'd0;
   localparam logic [2:0] REG_START_PHASE     = 3'd1;
   localparam logic [2:0] REG_PHASE_STEP      = 3'd2;
   localparam logic [2:0] REG_BURST_CYCLES    = 3'd3;
   localparam logic [2:0] REG_GAUSS_SHARPNESS = 3'd4;

   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_COSINE   = 2'd1;
   // Both remaining codes select no carrier.
   localparam logic [1:0] WAVE_NONE     = 2'd2;
   localparam logic [1:0] WAVE_RESERVED = 2'd3;

   localparam logic [1:0]  RST_WAVE_TYPE       = WAVE_SINE;
   localparam logic [31:0] RST_START_PHASE     = 32'd0;
   localparam logic [30:0] RST_PHASE_STEP      = 31'd104858;
   localparam logic [7:0]  RST_BURST_CYCLES    = 8'd3;
   localparam logic [7:0]  RST_GAUSS_SHARPNESS = 8'd0;

   // Pipeline depths.
   localparam int PH_LAT     = 5;
   localparam int DIV_STAGES = 8;
   localparam int DIV_BITS   = 4;
   localparam int EXP_TERMS  = 10;
   localparam int ENV_LAT    = DIV_STAGES + 3 + 3 * EXP_TERMS + 1;
   localparam int SIN_LAT    = 6;
   localparam int CAR_DLY    = ENV_LAT - SIN_LAT;
   localparam int PIPE_LAT   = PH_LAT + ENV_LAT + 2;

   // Fixed-point constants, Q30 unless noted.
   localparam logic [30:0] Q30_ONE   = 31'd1073741824;
   localparam logic [31:0] SIN_A1    = 32'd1686629713;
   localparam logic [31:0] SIN_A3    = 32'd693598669;
   localparam logic [31:0] SIN_A5    = 32'd85569306;
   localparam logic [31:0] SIN_A7    = 32'd5026995;
   localparam logic [31:0] SIN_A9    = 32'd172272;
   localparam logic [29:0] LOG2E_Q29 = 30'd774541003;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [22:0] FIVE_Q20  = 23'd5242880;
   localparam logic [19:0] QUARTER   = 20'h40000;
   localparam logic [14:0] MAG_LIMIT = 15'd16384;

   // floor(2^32 / k), so that x / k is (x * RECIP[k]) >> 32 plus at most one.
   localparam logic [32:0] RECIP [1:10] = '{
      33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
      33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
      33'd477218588,  33'd429496729
   };

   typedef struct packed {
      logic        inb;
      logic        neg;
      logic [30:0] z;
      logic        ez;
      logic [30:0] num;
   } phs_out_type;

   typedef struct packed {
      logic inb;
      logic use_car;
      logic neg;
      logic env_on;
   } side_type;

   typedef struct packed {
      logic [29:0] t;
      logic [4:0]  n;
      logic        ez;
   } exp_side_type;

endpackage

@@ hdl/gtb_phase.sv @@
`timescale 1ns / 1ps

module gtb_phase (
   input  logic                 clock,
   input  logic                 en,
   input  logic [15:0]          sample_index,
   input  logic [1:0]           wave_type,
   input  logic [31:0]          start_phase,
   input  logic [30:0]          phase_step,
   input  logic [7:0]           burst_cycles,
   input  logic [7:0]           gauss_sharpness,
   output gtb_pkg::phs_out_type phs_out
);

   logic [46:0] adv_ff;
   logic signed [48:0] phase_ff;
   logic inb2_ff, inb3_ff, inb4_ff, inb5_ff;
   logic neg3_ff, neg4_ff, neg5_ff;
   logic [30:0] z3_ff, z4_ff, z5_ff;
   logic [48:0] dmag_ff;
   logic [56:0] num_ff;
   logic ez5_ff;
   logic [30:0] num5_ff;

   logic [19:0] frac;
   logic [18:0] x;
   logic signed [49:0] d;
   logic [49:0] dabs;
   logic [30:0] limit;

   always_comb begin
      frac = phase_ff[19:0];
      if (wave_type == gtb_pkg::WAVE_COSINE) begin
         frac = frac + gtb_pkg::QUARTER;
      end
      x = {1'b0, frac[17:0]};
      if (frac[18]) begin
         x = {1'b0, gtb_pkg::QUARTER[17:0]} + 19'h40000 - {1'b0, frac[17:0]};
      end
      d = {phase_ff[48], phase_ff} - $signed({23'd0, burst_cycles, 19'd0});
      dabs = d[49] ? (50'd0 - $unsigned(d)) : $unsigned(d);
      limit = 31'(burst_cycles * gtb_pkg::FIVE_Q20);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         adv_ff   <= 47'(sample_index * phase_step);
         phase_ff <= $signed({{17{start_phase[31]}}, start_phase}) +
                     $signed({2'b00, adv_ff});
         inb2_ff  <= adv_ff <= {19'd0, burst_cycles, 20'd0};

         inb3_ff  <= inb2_ff;
         neg3_ff  <= frac[19];
         z3_ff    <= {x[18:0], 12'd0};
         dmag_ff  <= dabs[48:0];

         inb4_ff  <= inb3_ff;
         neg4_ff  <= neg3_ff;
         z4_ff    <= z3_ff;
         num_ff   <= 57'(dmag_ff * gauss_sharpness);

         inb5_ff  <= inb4_ff;
         neg5_ff  <= neg4_ff;
         z5_ff    <= z4_ff;
         // Past five standard deviations the envelope is exactly zero, which also
         // keeps the numerator of the division within 31 bits.
         ez5_ff   <= (burst_cycles == 8'd0) || ({num_ff, 1'b0} >= {27'd0, limit});
         num5_ff  <= {num_ff[29:0], 1'b0};
      end
   end

   assign phs_out.inb = inb5_ff;
   assign phs_out.neg = neg5_ff;
   assign phs_out.z   = z5_ff;
   assign phs_out.ez  = ez5_ff;
   assign phs_out.num = num5_ff;

endmodule

@@ hdl/gtb_sine.sv @@
`timescale 1ns / 1ps

module gtb_sine (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] z,
   output logic [30:0] carrier
);

   logic [30:0] z2_ff [0:3];
   logic [30:0] zd_ff [0:4];
   logic [31:0] p_ff [0:3];
   logic [30:0] car_ff;

   logic [61:0] zsq;
   logic [63:0] prod [0:3];
   logic [62:0] fin;

   localparam logic [31:0] COEF [0:3] = '{
      gtb_pkg::SIN_A7, gtb_pkg::SIN_A5, gtb_pkg::SIN_A3, gtb_pkg::SIN_A1
   };

   // The square travels alongside each Horner step so every step uses its own word.
   always_comb begin
      zsq = z * z;
      prod[0] = gtb_pkg::SIN_A9 * z2_ff[0];
      for (int i = 1; i < 4; i++) begin
         prod[i] = p_ff[i-1] * z2_ff[i];
      end
      fin = p_ff[3] * zd_ff[4];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z2_ff[0] <= zsq[60:30];
         for (int i = 1; i < 4; i++) begin
            z2_ff[i] <= z2_ff[i-1];
         end
         zd_ff[0] <= z;
         for (int i = 1; i < 5; i++) begin
            zd_ff[i] <= zd_ff[i-1];
         end
         for (int i = 0; i < 4; i++) begin
            p_ff[i] <= COEF[i] - prod[i][61:30];
         end
         car_ff <= fin[60:30];
      end
   end

   assign carrier = car_ff;

endmodule

@@ hdl/gtb_env.sv @@
`timescale 1ns / 1ps

module gtb_env (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] num,
   input  logic        ez,
   input  logic [7:0]  burst_cycles,
   output logic [30:0] envelope
);

   localparam int NT = gtb_pkg::EXP_TERMS;

   // Radix-2 restoring divider, four quotient bits per stage.
   logic [7:0]  rem_ff [0:gtb_pkg::DIV_STAGES-1];
   logic [31:0] dq_ff  [0:gtb_pkg::DIV_STAGES-1];
   logic        dez_ff [0:gtb_pkg::DIV_STAGES-1];
   logic [7:0]  rem_in [0:gtb_pkg::DIV_STAGES-1];
   logic [31:0] dq_in  [0:gtb_pkg::DIV_STAGES-1];

   logic [34:0] w_ff, y_ff;
   logic        ez1_ff, ez2_ff;
   gtb_pkg::exp_side_type s3_ff;

   logic [30:0] ma_ff [0:NT-1];
   logic [30:0] mb_ff [0:NT-1];
   logic [30:0] qb_ff [0:NT-1];
   logic [30:0] pc_ff [0:NT-1];
   gtb_pkg::exp_side_type sa_ff [0:NT-1];
   gtb_pkg::exp_side_type sb_ff [0:NT-1];
   gtb_pkg::exp_side_type sc_ff [0:NT-1];
   logic [30:0] env_ff;

   always_comb begin
      logic [7:0]  r;
      logic [31:0] q;
      logic [8:0]  tmp;
      for (int s = 0; s < gtb_pkg::DIV_STAGES; s++) begin
         if (s == 0) begin
            r = 8'd0;
            q = {1'b0, num};
         end else begin
            r = rem_ff[s-1];
            q = dq_ff[s-1];
         end
         for (int b = 0; b < gtb_pkg::DIV_BITS; b++) begin
            tmp = {r, q[31]};
            if (tmp >= {1'b0, burst_cycles}) begin
               tmp = tmp - {1'b0, burst_cycles};
               q = {q[30:0], 1'b1};
            end else begin
               q = {q[30:0], 1'b0};
            end
            r = tmp[7:0];
         end
         rem_in[s] = r;
         dq_in[s]  = q;
      end
   end

   logic [45:0] usq;
   logic [64:0] yl;
   logic [59:0] tl;
   logic [60:0] pt   [0:NT-1];
   logic [63:0] qe   [0:NT-1];
   logic [34:0] qk   [0:NT-1];
   logic [30:0] rr   [0:NT-1];
   logic [30:0] pnew [0:NT-1];

   always_comb begin
      usq = dq_ff[gtb_pkg::DIV_STAGES-1][22:0] * dq_ff[gtb_pkg::DIV_STAGES-1][22:0];
      yl  = w_ff * gtb_pkg::LOG2E_Q29;
      tl  = y_ff[29:0] * gtb_pkg::LN2_Q30;
      for (int j = 0; j < NT; j++) begin
         if (j == 0) begin
            pt[j] = gtb_pkg::Q30_ONE * s3_ff.t;
         end else begin
            pt[j] = pc_ff[j-1] * sc_ff[j-1].t;
         end
         qe[j] = ma_ff[j] * gtb_pkg::RECIP[NT-j];
         qk[j] = qb_ff[j] * 4'(NT-j);
         rr[j] = mb_ff[j] - qk[j][30:0];
         // The reciprocal estimate is low by at most one.
         if (rr[j] >= 31'(NT-j)) begin
            pnew[j] = gtb_pkg::Q30_ONE - (qb_ff[j] + 31'd1);
         end else begin
            pnew[j] = gtb_pkg::Q30_ONE - qb_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < gtb_pkg::DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            dq_ff[s]  <= dq_in[s];
         end
         dez_ff[0] <= ez;
         for (int s = 1; s < gtb_pkg::DIV_STAGES; s++) begin
            dez_ff[s] <= dez_ff[s-1];
         end
         w_ff   <= usq[45:11];
         ez1_ff <= dez_ff[gtb_pkg::DIV_STAGES-1];
         y_ff   <= yl[63:29];
         ez2_ff <= ez1_ff;
         s3_ff.t  <= tl[59:30];
         s3_ff.n  <= y_ff[34:30];
         s3_ff.ez <= ez2_ff;
         sa_ff[0] <= s3_ff;
         for (int j = 1; j < NT; j++) begin
            sa_ff[j] <= sc_ff[j-1];
         end
         for (int j = 0; j < NT; j++) begin
            ma_ff[j] <= pt[j][60:30];
            mb_ff[j] <= ma_ff[j];
            qb_ff[j] <= qe[j][62:32];
            sb_ff[j] <= sa_ff[j];
            pc_ff[j] <= pnew[j];
            sc_ff[j] <= sb_ff[j];
         end
         env_ff <= sc_ff[NT-1].ez ? 31'd0 : (pc_ff[NT-1] >> sc_ff[NT-1].n);
      end
   end

   assign envelope = env_ff;

endmodule

@@ hdl/gaussian_tone_burst_generator.sv @@
`timescale 1ns / 1ps
// Each accepted request word passes the phase, envelope and output registers to become its response word.
// Throughput: one word per cycle; the whole pipeline holds while a response is stalled.
// The envelope path (8-stage divider, exponent setup, 30-stage Horner series) sets depth.
// Reset: synchronous, active high; clears the valid bits and loads the register defaults.

module gaussian_tone_burst_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_sample_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_value,
   output logic               rsp_in_burst,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int LAT = gtb_pkg::PIPE_LAT;

   logic [1:0]  wave_type_ff;
   logic [31:0] start_phase_ff;
   logic [30:0] phase_step_ff;
   logic [7:0]  burst_cycles_ff;
   logic [7:0]  gauss_sharpness_ff;

   logic [LAT-1:0] vld_ff;
   logic en, wr;

   gtb_pkg::phs_out_type phs;
   logic [30:0] carrier, envelope;
   logic [30:0] car_dly_ff [0:gtb_pkg::CAR_DLY-1];
   gtb_pkg::side_type side_dly_ff [0:gtb_pkg::ENV_LAT-1];
   gtb_pkg::side_type side_in, side1_ff;
   logic [61:0] prod_ff;
   logic [30:0] car1_ff;
   logic signed [15:0] value_ff;
   logic inb_ff;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_type_ff       <= gtb_pkg::RST_WAVE_TYPE;
         start_phase_ff     <= gtb_pkg::RST_START_PHASE;
         phase_step_ff      <= gtb_pkg::RST_PHASE_STEP;
         burst_cycles_ff    <= gtb_pkg::RST_BURST_CYCLES;
         gauss_sharpness_ff <= gtb_pkg::RST_GAUSS_SHARPNESS;
      end else if (wr) begin
         case (csr_paddr[4:2])
            gtb_pkg::REG_WAVE_TYPE:       wave_type_ff       <= csr_pwdata[1:0];
            gtb_pkg::REG_START_PHASE:     start_phase_ff     <= csr_pwdata;
            gtb_pkg::REG_PHASE_STEP:      phase_step_ff      <= csr_pwdata[30:0];
            gtb_pkg::REG_BURST_CYCLES:    burst_cycles_ff    <= csr_pwdata[7:0];
            gtb_pkg::REG_GAUSS_SHARPNESS: gauss_sharpness_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         gtb_pkg::REG_WAVE_TYPE:       csr_prdata = {30'd0, wave_type_ff};
         gtb_pkg::REG_START_PHASE:     csr_prdata = start_phase_ff;
         gtb_pkg::REG_PHASE_STEP:      csr_prdata = {1'b0, phase_step_ff};
         gtb_pkg::REG_BURST_CYCLES:    csr_prdata = {24'd0, burst_cycles_ff};
         gtb_pkg::REG_GAUSS_SHARPNESS: csr_prdata = {24'd0, gauss_sharpness_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   gtb_phase u_phase (
      .clock           (clock),
      .en              (en),
      .sample_index    (req_sample_index),
      .wave_type       (wave_type_ff),
      .start_phase     (start_phase_ff),
      .phase_step      (phase_step_ff),
      .burst_cycles    (burst_cycles_ff),
      .gauss_sharpness (gauss_sharpness_ff),
      .phs_out         (phs)
   );

   gtb_sine u_sine (
      .clock   (clock),
      .en      (en),
      .z       (phs.z),
      .carrier (carrier)
   );

   gtb_env u_env (
      .clock        (clock),
      .en           (en),
      .num          (phs.num),
      .ez           (phs.ez),
      .burst_cycles (burst_cycles_ff),
      .envelope     (envelope)
   );

   always_comb begin
      side_in.inb     = phs.inb;
      side_in.use_car = (wave_type_ff == gtb_pkg::WAVE_SINE) ||
                        (wave_type_ff == gtb_pkg::WAVE_COSINE);
      side_in.neg     = phs.neg;
      side_in.env_on  = gauss_sharpness_ff != 8'd0;
   end

   logic [62:0] rnd_env;
   logic [31:0] rnd_car;
   logic [16:0] mag;
   logic [14:0] mag_sat;

   always_comb begin
      rnd_env = {1'b0, prod_ff} + (63'd1 << 45);
      rnd_car = {1'b0, car1_ff} + (32'd1 << 15);
      mag = side1_ff.env_on ? rnd_env[62:46] : {1'b0, rnd_car[31:16]};
      mag_sat = (mag > {2'b00, gtb_pkg::MAG_LIMIT}) ? gtb_pkg::MAG_LIMIT : mag[14:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         car_dly_ff[0] <= carrier;
         for (int i = 1; i < gtb_pkg::CAR_DLY; i++) begin
            car_dly_ff[i] <= car_dly_ff[i-1];
         end
         side_dly_ff[0] <= side_in;
         for (int i = 1; i < gtb_pkg::ENV_LAT; i++) begin
            side_dly_ff[i] <= side_dly_ff[i-1];
         end
         prod_ff  <= car_dly_ff[gtb_pkg::CAR_DLY-1] * envelope;
         car1_ff  <= car_dly_ff[gtb_pkg::CAR_DLY-1];
         side1_ff <= side_dly_ff[gtb_pkg::ENV_LAT-1];
         inb_ff   <= side1_ff.inb;
         if (!side1_ff.inb || !side1_ff.use_car) begin
            value_ff <= 16'sd0;
         end else if (side1_ff.neg) begin
            value_ff <= $signed(16'd0 - {1'b0, mag_sat});
         end else begin
            value_ff <= $signed({1'b0, mag_sat});
         end
      end
   end

   assign rsp_valid        = vld_ff[LAT-1];
   assign rsp_sample_value = value_ff;
   assign rsp_in_burst     = inb_ff;

   a_gate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_burst) |-> (rsp_sample_value == 16'sd0))
      else $error("sample outside the burst is not zero");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_value <= 16'sd16384 && rsp_sample_value >= -16'sd16384))
      else $error("sample magnitude beyond full scale");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

endmodule
